@@ hw/rtl/sptb_pkg.sv @@
// ----------------------------------------------------------------------------
// sptb_pkg
// Types and constants shared by the speed PID throttle/brake controller.
// ----------------------------------------------------------------------------
package sptb_pkg;

   localparam int GAIN_W  = 16;
   localparam int SPEED_W = 16;
   localparam int PCT_W   = 7;
   localparam int FRAC_W  = 16;
   localparam int ACC_W   = 32;
   localparam int SUM_W   = 51;
   localparam int ADDR_W  = 5;
   localparam int DATA_W  = 32;

   localparam int SNAP_HIGH = 90;
   localparam int SNAP_LOW  = 10;

   localparam logic [PCT_W-1:0] SNAP_FULL        = 7'd100;
   localparam logic [PCT_W-1:0] THROTTLE_CAP_RST = 7'd60;
   localparam logic [PCT_W-1:0] BRAKE_CAP_RST    = 7'd88;

   typedef enum logic [2:0] {
      REG_THROTTLE_PROP  = 3'd0,
      REG_THROTTLE_INTEG = 3'd1,
      REG_THROTTLE_DERIV = 3'd2,
      REG_BRAKE_PROP     = 3'd3,
      REG_BRAKE_INTEG    = 3'd4,
      REG_BRAKE_DERIV    = 3'd5,
      REG_THROTTLE_CAP   = 3'd6,
      REG_BRAKE_CAP      = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0] throttle_prop_gain;
      logic [GAIN_W-1:0] throttle_integ_gain;
      logic [GAIN_W-1:0] throttle_deriv_gain;
      logic [GAIN_W-1:0] brake_prop_gain;
      logic [GAIN_W-1:0] brake_integ_gain;
      logic [GAIN_W-1:0] brake_deriv_gain;
      logic [PCT_W-1:0]  throttle_cap;
      logic [PCT_W-1:0]  brake_cap;
   } cfg_type;

endpackage

@@ hw/rtl/speed_pid_throttle_brake.sv @@
// ----------------------------------------------------------------------------
// speed_pid_throttle_brake
// Speed controller: throttle PID with a brake PID fallback, one result a tick unless stalled.
// ----------------------------------------------------------------------------
// Takes one word per clock while req_stall is low. An accepted word sits in
// the input register, passes the throttle and brake PID datapath (six gain
// multipliers side by side, the two sums and the snap/cap logic) and lands
// in the result register once that register is empty or not stalled.
// That single pass also closes the loop on the integrator and derivative
// state, which sets the clock period. Input and result registers let a new
// word enter while the previous result still waits on rsp_stall. Gains and
// caps sit behind the APB port and should be written only while idle.
// ----------------------------------------------------------------------------
module speed_pid_throttle_brake (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [sptb_pkg::SPEED_W-1:0]  req_target_speed,
   input  logic [sptb_pkg::SPEED_W-1:0]  req_measured_speed,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [sptb_pkg::PCT_W-1:0]    rsp_accel_percent,
   output logic [sptb_pkg::PCT_W-1:0]    rsp_brake_percent,

   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [sptb_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [sptb_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [sptb_pkg::DATA_W-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import sptb_pkg::*;

   cfg_type             cfg;

   logic                in_valid_ff, in_valid_in;
   logic [SPEED_W-1:0]  in_target_ff, in_target_in;
   logic [SPEED_W-1:0]  in_measured_ff, in_measured_in;
   logic                out_valid_ff, out_valid_in;
   logic [PCT_W-1:0]    out_accel_ff, out_accel_in;
   logic [PCT_W-1:0]    out_brake_ff, out_brake_in;

   logic                accept;
   logic                advance;
   logic [PCT_W-1:0]    core_accel;
   logic [PCT_W-1:0]    core_brake;

   sptb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   sptb_core u_core (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .fire           (advance),
      .target_speed   (in_target_ff),
      .measured_speed (in_measured_ff),
      .accel_percent  (core_accel),
      .brake_percent  (core_brake)
   );

   assign advance   = in_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall = in_valid_ff & out_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign rsp_valid         = out_valid_ff;
   assign rsp_accel_percent = out_accel_ff;
   assign rsp_brake_percent = out_brake_ff;

   always_comb begin
      in_valid_in    = accept | (in_valid_ff & ~advance);
      in_target_in   = accept ? req_target_speed : in_target_ff;
      in_measured_in = accept ? req_measured_speed : in_measured_ff;

      out_valid_in = advance | (out_valid_ff & rsp_stall);
      out_accel_in = advance ? core_accel : out_accel_ff;
      out_brake_in = advance ? core_brake : out_brake_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_target_ff   <= in_target_in;
      in_measured_ff <= in_measured_in;
      out_accel_ff   <= out_accel_in;
      out_brake_ff   <= out_brake_in;
   end

   a_one_actuator: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_accel_percent == '0) || (rsp_brake_percent == '0))
      else $error("accel and brake both active");

   a_accel_capped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_accel_percent <= cfg.throttle_cap)
      else $error("accel above throttle cap");

   a_brake_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_brake_percent <= SNAP_FULL) || (rsp_brake_percent == cfg.brake_cap))
      else $error("brake outside snapped range");

   a_advance_lands: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced word did not reach result register");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && rsp_stall)
      |=> in_valid_ff && $stable(in_target_ff) && $stable(in_measured_ff))
      else $error("input register overwritten while blocked");

endmodule

@@ hw/rtl/sptb_csr.sv @@
// ----------------------------------------------------------------------------
// sptb_csr
// APB register file holding the PID gains and the throttle and brake caps.
// ----------------------------------------------------------------------------
module sptb_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [sptb_pkg::ADDR_W-1:0]  paddr,
   input  logic [sptb_pkg::DATA_W-1:0]  pwdata,
   output logic [sptb_pkg::DATA_W-1:0]  prdata,
   output logic                         pready,
   output sptb_pkg::cfg_type            cfg
);
   import sptb_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          write_en;

   assign index    = reg_index_type'(paddr[ADDR_W-1:2]);
   assign write_en = psel & penable & pwrite;
   assign pready   = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            REG_THROTTLE_PROP:  cfg_in.throttle_prop_gain  = pwdata[GAIN_W-1:0];
            REG_THROTTLE_INTEG: cfg_in.throttle_integ_gain = pwdata[GAIN_W-1:0];
            REG_THROTTLE_DERIV: cfg_in.throttle_deriv_gain = pwdata[GAIN_W-1:0];
            REG_BRAKE_PROP:     cfg_in.brake_prop_gain     = pwdata[GAIN_W-1:0];
            REG_BRAKE_INTEG:    cfg_in.brake_integ_gain    = pwdata[GAIN_W-1:0];
            REG_BRAKE_DERIV:    cfg_in.brake_deriv_gain    = pwdata[GAIN_W-1:0];
            REG_THROTTLE_CAP:   cfg_in.throttle_cap        = pwdata[PCT_W-1:0];
            REG_BRAKE_CAP:      cfg_in.brake_cap           = pwdata[PCT_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_THROTTLE_PROP:  prdata = DATA_W'(cfg_ff.throttle_prop_gain);
         REG_THROTTLE_INTEG: prdata = DATA_W'(cfg_ff.throttle_integ_gain);
         REG_THROTTLE_DERIV: prdata = DATA_W'(cfg_ff.throttle_deriv_gain);
         REG_BRAKE_PROP:     prdata = DATA_W'(cfg_ff.brake_prop_gain);
         REG_BRAKE_INTEG:    prdata = DATA_W'(cfg_ff.brake_integ_gain);
         REG_BRAKE_DERIV:    prdata = DATA_W'(cfg_ff.brake_deriv_gain);
         REG_THROTTLE_CAP:   prdata = DATA_W'(cfg_ff.throttle_cap);
         REG_BRAKE_CAP:      prdata = DATA_W'(cfg_ff.brake_cap);
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{throttle_prop_gain:  '0,
                     throttle_integ_gain: '0,
                     throttle_deriv_gain: '0,
                     brake_prop_gain:     '0,
                     brake_integ_gain:    '0,
                     brake_deriv_gain:    '0,
                     throttle_cap:        THROTTLE_CAP_RST,
                     brake_cap:           BRAKE_CAP_RST};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ hw/rtl/sptb_core.sv @@
// ----------------------------------------------------------------------------
// sptb_core
// Throttle and brake PID datapath with integrator and derivative state.
// ----------------------------------------------------------------------------
module sptb_core (
   input  logic                          clock,
   input  logic                          reset,
   input  sptb_pkg::cfg_type             cfg,
   input  logic                          fire,
   input  logic [sptb_pkg::SPEED_W-1:0]  target_speed,
   input  logic [sptb_pkg::SPEED_W-1:0]  measured_speed,
   output logic [sptb_pkg::PCT_W-1:0]    accel_percent,
   output logic [sptb_pkg::PCT_W-1:0]    brake_percent
);
   import sptb_pkg::*;

   localparam logic signed [SUM_W-1:0] BRAKE_HI_Q = SUM_W'(SNAP_HIGH * (2 ** FRAC_W));
   localparam logic signed [SUM_W-1:0] BRAKE_LO_Q = SUM_W'(SNAP_LOW * (2 ** FRAC_W));

   logic signed [SPEED_W:0]        prev_terr_ff, prev_terr_in;
   logic signed [ACC_W-1:0]        terr_acc_ff, terr_acc_in, terr_acc_new;
   logic [SPEED_W-1:0]             prev_berr_ff, prev_berr_in;
   logic [ACC_W-1:0]               berr_acc_ff, berr_acc_in, berr_acc_new;

   logic signed [SPEED_W:0]        err;
   logic signed [SPEED_W+1:0]      derr;
   logic signed [ACC_W:0]          tsum;
   logic signed [GAIN_W+SPEED_W+1:0] tp_prop;
   logic signed [GAIN_W+ACC_W:0]   tp_int;
   logic signed [GAIN_W+SPEED_W+2:0] tp_der;
   logic signed [SUM_W-1:0]        p;
   logic [SUM_W-FRAC_W-1:0]        whole;

   logic [SPEED_W-1:0]             eb;
   logic signed [SPEED_W:0]        dbe;
   logic [ACC_W:0]                 bsum;
   logic [GAIN_W+SPEED_W-1:0]      bp_prop;
   logic [GAIN_W+ACC_W-1:0]        bp_int;
   logic signed [GAIN_W+SPEED_W+1:0] bp_der;
   logic signed [SUM_W-1:0]        b;
   logic [PCT_W-1:0]               bsnap;
   logic                           brake_path;

   always_comb begin
      err  = $signed({1'b0, target_speed}) - $signed({1'b0, measured_speed});
      derr = (SPEED_W+2)'(err) - (SPEED_W+2)'(prev_terr_ff);
      tsum = (ACC_W+1)'(terr_acc_ff) + (ACC_W+1)'(err);
      if (tsum[ACC_W] != tsum[ACC_W-1]) begin
         terr_acc_new = tsum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         terr_acc_new = tsum[ACC_W-1:0];
      end

      tp_prop = $signed({1'b0, cfg.throttle_prop_gain}) * err;
      tp_int  = $signed({1'b0, cfg.throttle_integ_gain}) * terr_acc_new;
      tp_der  = $signed({1'b0, cfg.throttle_deriv_gain}) * derr;
      p       = SUM_W'(tp_prop) + SUM_W'(tp_int) + SUM_W'(tp_der);
      whole   = p[SUM_W-1:FRAC_W];

      accel_percent = '0;
      if (!p[SUM_W-1] && (p != '0)) begin
         if (whole > (SUM_W-FRAC_W)'(cfg.throttle_cap)) begin
            accel_percent = cfg.throttle_cap;
         end else begin
            accel_percent = whole[PCT_W-1:0];
         end
      end
      brake_path = (accel_percent == '0);

      eb   = err[SPEED_W] ? SPEED_W'(-err) : err[SPEED_W-1:0];
      dbe  = $signed({1'b0, eb}) - $signed({1'b0, prev_berr_ff});
      bsum = {1'b0, berr_acc_ff} + (ACC_W+1)'(eb);
      berr_acc_new = bsum[ACC_W] ? '1 : bsum[ACC_W-1:0];

      bp_prop = cfg.brake_prop_gain * eb;
      bp_int  = cfg.brake_integ_gain * berr_acc_new;
      bp_der  = $signed({1'b0, cfg.brake_deriv_gain}) * dbe;
      b       = $signed(SUM_W'(bp_prop)) + $signed(SUM_W'(bp_int)) + SUM_W'(bp_der);

      if (b >= BRAKE_HI_Q) begin
         bsnap = SNAP_FULL;
      end else if (b <= BRAKE_LO_Q) begin
         bsnap = '0;
      end else begin
         bsnap = b[FRAC_W+PCT_W-1:FRAC_W];
      end

      brake_percent = '0;
      if (brake_path) begin
         if ((target_speed == '0) || (bsnap >= cfg.brake_cap)) begin
            brake_percent = cfg.brake_cap;
         end else begin
            brake_percent = bsnap;
         end
      end

      prev_terr_in = prev_terr_ff;
      terr_acc_in  = terr_acc_ff;
      prev_berr_in = prev_berr_ff;
      berr_acc_in  = berr_acc_ff;
      if (fire) begin
         prev_terr_in = err;
         terr_acc_in  = terr_acc_new;
         if (brake_path) begin
            prev_berr_in = eb;
            berr_acc_in  = berr_acc_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_terr_ff <= '0;
         terr_acc_ff  <= '0;
         prev_berr_ff <= '0;
         berr_acc_ff  <= '0;
      end else begin
         prev_terr_ff <= prev_terr_in;
         terr_acc_ff  <= terr_acc_in;
         prev_berr_ff <= prev_berr_in;
         berr_acc_ff  <= berr_acc_in;
      end
   end

endmodule
